// ----- rtl/rtoeb_pkg.sv -----
// ----------------------------------------------------------------------------
// RTO estimator package
// Shared constants for the retransmission-timeout estimator: widths, opcodes,
// configuration register map and reset values.
// ----------------------------------------------------------------------------
package rtoeb_pkg;

  // Default width of every duration (timeouts, timer, estimates).
  localparam int TIME_BITS_DEF = 40;
  // Width of the send and receive timestamps.
  localparam int TS_BITS       = 48;
  localparam int RETRY_BITS    = 8;
  localparam int OP_BITS       = 2;

  // Configuration port geometry: registers sit on 8-byte boundaries.
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;
  localparam int CFG_IDX_LSB   = 3;
  localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - CFG_IDX_LSB;

  typedef logic [OP_BITS-1:0]      opcode_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // Request opcodes.
  localparam opcode_t OP_ARM     = 2'd0;
  localparam opcode_t OP_SAMPLE  = 2'd1;
  localparam opcode_t OP_TIMEOUT = 2'd2;
  localparam opcode_t OP_NONE    = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t REG_AUTO_RTO       = 3'd0;
  localparam cfg_idx_t REG_USER_RTO_NS    = 3'd1;
  localparam cfg_idx_t REG_RTO_MIN_NS     = 3'd2;
  localparam cfg_idx_t REG_RTO_MAX_NS     = 3'd3;
  localparam cfg_idx_t REG_MAX_RETRANSMIT = 3'd4;

  // Reset values, given at 64 bits and saturated to the duration width.
  localparam logic [63:0] INITIAL_RTO_NS     = 64'd1000000000;
  localparam logic [63:0] USER_RTO_RST       = 64'd1000000000;
  localparam logic [63:0] RTO_MIN_RST        = 64'd200000000;
  localparam logic [63:0] RTO_MAX_RST        = 64'd60000000000;
  localparam logic [RETRY_BITS-1:0] MAX_RETRANSMIT_RST = 8'd10;

  localparam logic [RETRY_BITS-1:0] RETRY_MAX = {RETRY_BITS{1'b1}};

  // Shift amounts of the smoothing gains (1/8 and 1/4) and the 4x deviation.
  localparam int SRTT_SHIFT   = 3;
  localparam int RTTVAR_SHIFT = 2;
  localparam int VAR_MUL_SH   = 2;

endpackage

// ----- rtl/rto_estimator_backoff_top.sv -----
// ----------------------------------------------------------------------------
// RTO estimator with exponential backoff
// Flow: each accepted request is held in the input register, then updates the
// estimator state in the state/result registers. Throughput: one request per
// cycle while the result consumer keeps up; a stalled result holds the flow.
// Reset (synchronous, rst_n low) restores the default configuration and
// clears the estimates; RTO and timer restart at one second.
// ----------------------------------------------------------------------------
module rto_estimator_backoff_top #(
  parameter int TIME_BITS = rtoeb_pkg::TIME_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  // Request channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rtoeb_pkg::opcode_t                   in_opcode,
  input  logic [rtoeb_pkg::TS_BITS-1:0]        in_send_time_ns,
  input  logic [rtoeb_pkg::TS_BITS-1:0]        in_receive_time_ns,

  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [TIME_BITS-1:0]                 out_rto_ns,
  output logic [TIME_BITS-1:0]                 out_timer_ns,
  output logic [TIME_BITS-1:0]                 out_srtt_ns,
  output logic [TIME_BITS-1:0]                 out_rttvar_ns,
  output logic [rtoeb_pkg::RETRY_BITS-1:0]     out_retry_count,
  output logic                                 out_give_up,

  // Configuration port.
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [rtoeb_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [rtoeb_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [rtoeb_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                 cfg_pready
);

  // Largest duration; every duration saturates here.
  localparam logic [63:0] TMAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TIME_BITS);
  localparam logic [TIME_BITS-1:0] TMAX = TIME_BITS'(TMAX64);
  localparam logic [TIME_BITS-1:0] TMAX_HALF = TMAX >> 1;

  // Reset values saturated to the duration width.
  localparam logic [TIME_BITS-1:0] RTO_INIT =
    (rtoeb_pkg::INITIAL_RTO_NS > TMAX64) ? TMAX : TIME_BITS'(rtoeb_pkg::INITIAL_RTO_NS);
  localparam logic [TIME_BITS-1:0] USER_INIT =
    (rtoeb_pkg::USER_RTO_RST > TMAX64) ? TMAX : TIME_BITS'(rtoeb_pkg::USER_RTO_RST);
  localparam logic [TIME_BITS-1:0] MIN_INIT =
    (rtoeb_pkg::RTO_MIN_RST > TMAX64) ? TMAX : TIME_BITS'(rtoeb_pkg::RTO_MIN_RST);
  localparam logic [TIME_BITS-1:0] MAX_INIT =
    (rtoeb_pkg::RTO_MAX_RST > TMAX64) ? TMAX : TIME_BITS'(rtoeb_pkg::RTO_MAX_RST);

  // Width that holds both a timestamp difference and a duration.
  localparam int WB = (TIME_BITS > rtoeb_pkg::TS_BITS) ? TIME_BITS : rtoeb_pkg::TS_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers. The port never waits; a write lands on the
  // access cycle. Software must only write while the estimator is idle, so
  // no request in flight sees a half-updated configuration (the block does not enforce it).
  // --------------------------------------------------------------------------
  logic                                auto_r;
  logic [TIME_BITS-1:0]                user_r;
  logic [TIME_BITS-1:0]                min_r;
  logic [TIME_BITS-1:0]                max_r;
  logic [rtoeb_pkg::RETRY_BITS-1:0]    max_rt_r;

  logic                                cfg_wr;
  rtoeb_pkg::cfg_idx_t                 cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[rtoeb_pkg::CFG_ADDR_BITS-1:rtoeb_pkg::CFG_IDX_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r   <= 1'b1;
      user_r   <= USER_INIT;
      min_r    <= MIN_INIT;
      max_r    <= MAX_INIT;
      max_rt_r <= rtoeb_pkg::MAX_RETRANSMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rtoeb_pkg::REG_AUTO_RTO:       auto_r   <= cfg_pwdata[0];
        rtoeb_pkg::REG_USER_RTO_NS:    user_r   <= cfg_pwdata[TIME_BITS-1:0];
        rtoeb_pkg::REG_RTO_MIN_NS:     min_r    <= cfg_pwdata[TIME_BITS-1:0];
        rtoeb_pkg::REG_RTO_MAX_NS:     max_r    <= cfg_pwdata[TIME_BITS-1:0];
        rtoeb_pkg::REG_MAX_RETRANSMIT: max_rt_r <= cfg_pwdata[rtoeb_pkg::RETRY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back: each register zero-extended to the bus.
  always_comb begin
    unique case (cfg_idx)
      rtoeb_pkg::REG_AUTO_RTO:       cfg_prdata = rtoeb_pkg::CFG_DATA_BITS'(auto_r);
      rtoeb_pkg::REG_USER_RTO_NS:    cfg_prdata = rtoeb_pkg::CFG_DATA_BITS'(user_r);
      rtoeb_pkg::REG_RTO_MIN_NS:     cfg_prdata = rtoeb_pkg::CFG_DATA_BITS'(min_r);
      rtoeb_pkg::REG_RTO_MAX_NS:     cfg_prdata = rtoeb_pkg::CFG_DATA_BITS'(max_r);
      rtoeb_pkg::REG_MAX_RETRANSMIT: cfg_prdata = rtoeb_pkg::CFG_DATA_BITS'(max_rt_r);
      default:                       cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage one is the input register. The estimator state
  // registers double as the result register: the state is only updated when
  // the result slot is free or being taken, so the state always equals the result on show.
  // A request moves from stage one into the state whenever the result slot is
  // empty or is being taken in the same cycle, which keeps one request per
  // cycle flowing while the consumer keeps up.
  // --------------------------------------------------------------------------
  logic                              s1_vld_r;
  rtoeb_pkg::opcode_t                s1_op_r;
  logic [rtoeb_pkg::TS_BITS-1:0]     s1_send_r;
  logic [rtoeb_pkg::TS_BITS-1:0]     s1_recv_r;
  logic                              out_vld_r;
  logic                              s1_adv;
  logic                              in_acc;

  assign s1_adv   = s1_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~s1_vld_r | s1_adv;
  assign in_acc   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_opcode;
      s1_send_r <= in_send_time_ns;
      s1_recv_r <= in_receive_time_ns;
    end
  end

  // --------------------------------------------------------------------------
  // Estimator state.
  // --------------------------------------------------------------------------
  logic [TIME_BITS-1:0]             srtt_r,    srtt_nxt;
  logic [TIME_BITS-1:0]             rttvar_r,  rttvar_nxt;
  logic [TIME_BITS-1:0]             rto_r,     rto_nxt;
  logic [TIME_BITS-1:0]             timer_r,   timer_nxt;
  logic [rtoeb_pkg::RETRY_BITS-1:0] retries_r, retries_nxt;
  logic                             failed_r,  failed_nxt;

  // Clamp to [min, max]; when the bounds cross, values above the maximum go to the maximum and the rest to the minimum.
  function automatic logic [TIME_BITS-1:0] clamp_rto(
    input logic [TIME_BITS-1:0] v,
    input logic [TIME_BITS-1:0] lo,
    input logic [TIME_BITS-1:0] hi
  );
    logic [TIME_BITS-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // In manual mode the RTO is refreshed from the user value on every request,
  // before the opcode acts; an arm in manual mode loads the timer from it.
  logic [TIME_BITS-1:0]          rto_cur;
  assign rto_cur = auto_r ? rto_r : clamp_rto(user_r, min_r, max_r);

  // Measured RTT: negative differences read as zero, long ones saturate.
  logic [rtoeb_pkg::TS_BITS-1:0] ts_diff;
  logic [WB-1:0]                 rtt_w;
  logic [TIME_BITS-1:0]          rtt;
  assign ts_diff = (s1_recv_r > s1_send_r) ? (s1_recv_r - s1_send_r) : '0;
  assign rtt_w   = WB'(ts_diff);
  assign rtt     = (rtt_w > WB'(TMAX)) ? TMAX : rtt_w[TIME_BITS-1:0];

  // SRTT moves an eighth of the way toward the sample, truncated toward zero.
  logic [TIME_BITS-1:0]          srtt_upd;
  assign srtt_upd = (rtt >= srtt_r) ?
                    srtt_r + ((rtt - srtt_r) >> rtoeb_pkg::SRTT_SHIFT) :
                    srtt_r - ((srtt_r - rtt) >> rtoeb_pkg::SRTT_SHIFT);

  // The deviation is measured against the already updated SRTT.
  logic [TIME_BITS-1:0]          dev;
  logic [TIME_BITS-1:0]          rttvar_upd;
  assign dev        = (rtt >= srtt_upd) ? (rtt - srtt_upd) : (srtt_upd - rtt);
  assign rttvar_upd = (dev >= rttvar_r) ?
                      rttvar_r + ((dev - rttvar_r) >> rtoeb_pkg::RTTVAR_SHIFT) :
                      rttvar_r - ((rttvar_r - dev) >> rtoeb_pkg::RTTVAR_SHIFT);

  // SRTT + 4*RTTVAR, saturating: it overflows exactly when RTTVAR exceeds a
  // quarter of the headroom left above SRTT.
  logic [TIME_BITS-1:0]          room_q;
  logic [TIME_BITS-1:0]          rto_sum;
  assign room_q  = (TMAX - srtt_upd) >> rtoeb_pkg::VAR_MUL_SH;
  assign rto_sum = (rttvar_upd > room_q) ? TMAX :
                   srtt_upd + (rttvar_upd << rtoeb_pkg::VAR_MUL_SH);

  // Backoff: double the timer with saturation, then clamp.
  logic [TIME_BITS-1:0]             timer_dbl;
  logic [rtoeb_pkg::RETRY_BITS-1:0] retries_inc;
  assign timer_dbl   = (timer_r > TMAX_HALF) ? TMAX : (timer_r << 1);
  assign retries_inc = (retries_r == rtoeb_pkg::RETRY_MAX) ? retries_r :
                       retries_r + rtoeb_pkg::RETRY_BITS'(1);

  always_comb begin
    srtt_nxt    = srtt_r;
    rttvar_nxt  = rttvar_r;
    rto_nxt     = rto_cur;
    timer_nxt   = timer_r;
    retries_nxt = retries_r;
    failed_nxt  = failed_r;
    case (s1_op_r)
      rtoeb_pkg::OP_ARM: begin
        timer_nxt   = rto_cur;
        retries_nxt = '0;
        failed_nxt  = 1'b0;
      end
      rtoeb_pkg::OP_SAMPLE: begin
        srtt_nxt   = srtt_upd;
        rttvar_nxt = rttvar_upd;
        if (auto_r) begin
          rto_nxt = clamp_rto(rto_sum, min_r, max_r);
        end
      end
      rtoeb_pkg::OP_TIMEOUT: begin
        timer_nxt   = clamp_rto(timer_dbl, min_r, max_r);
        retries_nxt = retries_inc;
        if (retries_inc > max_rt_r) begin
          failed_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r    <= '0;
      rttvar_r  <= '0;
      rto_r     <= RTO_INIT;
      timer_r   <= RTO_INIT;
      retries_r <= '0;
      failed_r  <= 1'b0;
    end else if (s1_adv) begin
      srtt_r    <= srtt_nxt;
      rttvar_r  <= rttvar_nxt;
      rto_r     <= rto_nxt;
      timer_r   <= timer_nxt;
      retries_r <= retries_nxt;
      failed_r  <= failed_nxt;
    end
  end

  // The result fields are the state after the request.
  assign out_valid       = out_vld_r;
  assign out_rto_ns      = rto_r;
  assign out_timer_ns    = timer_r;
  assign out_srtt_ns     = srtt_r;
  assign out_rttvar_ns   = rttvar_r;
  assign out_retry_count = retries_r;
  assign out_give_up     = failed_r;

`ifndef SYNTHESIS
  // Give-up only rises on a timeout request.
  a_giveup_on_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(failed_r) |-> $past(s1_adv && (s1_op_r == rtoeb_pkg::OP_TIMEOUT)))
    else $error("give-up flag rose without a timeout request");

  // The state, and thus the shown result, holds while no request advances.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(srtt_r) && $stable(rttvar_r) && $stable(timer_r)
                 && $stable(retries_r)))
    else $error("estimator state changed without an advancing request");

  // With sane bounds a backed-off timer lands inside them.
  a_timer_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_op_r == rtoeb_pkg::OP_TIMEOUT) && (min_r <= max_r)) |=>
    ((timer_r >= $past(min_r)) && (timer_r <= $past(max_r))))
    else $error("backoff timer outside the clamp range");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTO estimator with backoff - self-checking bench
// Drives arm, RTT sample, timeout and unused-opcode requests through the
// request channel under random bursts and result back-pressure, predicts each
// result with a cycle-free model of the estimator and compares every field.
// The configuration registers are rewritten between traffic phases, covering
// manual and adaptive mode, open and collapsed clamp windows and retry limits.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          TW           = rtoeb_pkg::TIME_BITS_DEF;
  localparam logic [63:0] DUR_MAX      = (64'd1 << TW) - 64'd1;
  localparam logic [63:0] RUN_LIMIT_NS = 64'd1000000;
  localparam int          MAX_REPORTS  = 10;

  typedef logic [TW-1:0]                    dur_t;
  typedef logic [rtoeb_pkg::TS_BITS-1:0]    ts_t;
  typedef logic [rtoeb_pkg::RETRY_BITS-1:0] retry_t;

  localparam ts_t TS_MAX = {rtoeb_pkg::TS_BITS{1'b1}};

  // One request on the input channel.
  typedef struct {
    rtoeb_pkg::opcode_t op;
    ts_t                send_ns;
    ts_t                recv_ns;
  } rto_req_t;

  // Estimator state reported with every result.
  typedef struct {
    dur_t   rto;
    dur_t   timer;
    dur_t   srtt;
    dur_t   rttvar;
    retry_t retries;
    logic   give_up;
  } rto_result_t;

  // Receiver back-pressure styles, picked at random by the receiver.
  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_LIGHT} rx_mode_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  logic                     in_valid           = 1'b0;
  logic                     in_ready;
  rtoeb_pkg::opcode_t       in_opcode          = rtoeb_pkg::OP_ARM;
  ts_t                      in_send_time_ns    = '0;
  ts_t                      in_receive_time_ns = '0;

  logic                     out_valid;
  logic                     out_ready          = 1'b0;
  logic [TW-1:0]            out_rto_ns;
  logic [TW-1:0]            out_timer_ns;
  logic [TW-1:0]            out_srtt_ns;
  logic [TW-1:0]            out_rttvar_ns;
  retry_t                   out_retry_count;
  logic                     out_give_up;

  logic                                cfg_psel    = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite  = 1'b0;
  logic [rtoeb_pkg::CFG_ADDR_BITS-1:0] cfg_paddr   = '0;
  logic [rtoeb_pkg::CFG_DATA_BITS-1:0] cfg_pwdata  = '0;
  logic [rtoeb_pkg::CFG_DATA_BITS-1:0] cfg_prdata;
  logic                                cfg_pready;

  rto_estimator_backoff_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_send_time_ns    (in_send_time_ns),
    .in_receive_time_ns (in_receive_time_ns),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_rto_ns         (out_rto_ns),
    .out_timer_ns       (out_timer_ns),
    .out_srtt_ns        (out_srtt_ns),
    .out_rttvar_ns      (out_rttvar_ns),
    .out_retry_count    (out_retry_count),
    .out_give_up        (out_give_up),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Bench bookkeeping.
  // --------------------------------------------------------------------------
  rto_req_t    req_backlog[$];      // requests waiting for the driver
  rto_result_t pending_results[$];  // predicted results, oldest first

  logic req_taken    = 1'b0;  // request handshake seen at the last rising edge
  int   reqs_queued  = 0;
  int   results_seen = 0;
  int   err_count    = 0;

  int n_arm = 0, n_sample = 0, n_timeout = 0, n_unused = 0;
  int n_settings = 0, n_give_up = 0, n_retry_sat = 0;

  // Our copy of the configuration registers, updated as each write lands.
  logic   set_auto;
  dur_t   set_user;
  dur_t   set_min;
  dur_t   set_max;
  retry_t set_retx;

  // Our copy of the estimator state.
  dur_t   est_srtt;
  dur_t   est_rttvar;
  dur_t   est_rto;
  dur_t   est_timer;
  retry_t est_retries;
  logic   est_give_up;

  task automatic flag_error(string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      flag_error($sformatf("%s expected 0x%0h, got 0x%0h", fname, want, got));
    end
  endtask

  // --------------------------------------------------------------------------
  // Estimator prediction. All arithmetic is done at 64 bits and narrowed to
  // the duration width only once a value is known to fit.
  // --------------------------------------------------------------------------
  function automatic logic [63:0] sat_dur(logic [63:0] v);
    return (v > DUR_MAX) ? DUR_MAX : v;
  endfunction

  // Above the maximum wins over below the minimum, so a window whose minimum
  // lies above its maximum pins everything large to the maximum.
  function automatic dur_t clamp_window(logic [63:0] v);
    logic [63:0] c;
    c = v;
    if (c > 64'(set_max)) begin
      c = 64'(set_max);
    end else if (c < 64'(set_min)) begin
      c = 64'(set_min);
    end
    return dur_t'(sat_dur(c));
  endfunction

  // Move cur toward target by a 2^-sh fraction of the gap, truncating the
  // step toward zero in either direction.
  function automatic logic [63:0] ease_toward(logic [63:0] cur, logic [63:0] target,
                                              int sh);
    if (target >= cur) begin
      return cur + ((target - cur) >> sh);
    end
    return cur - ((cur - target) >> sh);
  endfunction

  function automatic rto_result_t advance_estimator(rto_req_t r);
    logic [63:0] rtt;
    logic [63:0] dev;
    logic [63:0] sum;
    logic [63:0] doubled;
    rto_result_t res;
    // In manual mode the user value is reapplied before every request.
    if (!set_auto) begin
      est_rto = clamp_window(64'(set_user));
    end
    case (r.op)
      rtoeb_pkg::OP_ARM: begin
        est_timer   = est_rto;
        est_retries = '0;
        est_give_up = 1'b0;
      end
      rtoeb_pkg::OP_SAMPLE: begin
        rtt = (r.recv_ns > r.send_ns) ?
              sat_dur(64'(r.recv_ns) - 64'(r.send_ns)) : 64'd0;
        est_srtt = dur_t'(ease_toward(64'(est_srtt), rtt, rtoeb_pkg::SRTT_SHIFT));
        // The deviation is taken against the already updated SRTT.
        dev = (rtt >= 64'(est_srtt)) ? rtt - 64'(est_srtt) : 64'(est_srtt) - rtt;
        est_rttvar = dur_t'(ease_toward(64'(est_rttvar), dev, rtoeb_pkg::RTTVAR_SHIFT));
        if (64'(est_rttvar) > ((DUR_MAX - 64'(est_srtt)) >> 2)) begin
          sum = DUR_MAX;
        end else begin
          sum = 64'(est_srtt) + (64'(est_rttvar) << rtoeb_pkg::VAR_MUL_SH);
        end
        if (set_auto) begin
          est_rto = clamp_window(sum);
        end
      end
      rtoeb_pkg::OP_TIMEOUT: begin
        doubled = (64'(est_timer) > (DUR_MAX >> 1)) ? DUR_MAX : 64'(est_timer) << 1;
        est_timer = clamp_window(doubled);
        if (est_retries != rtoeb_pkg::RETRY_MAX) begin
          est_retries = est_retries + retry_t'(1);
        end
        if (est_retries > set_retx) begin
          est_give_up = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.rto     = est_rto;
    res.timer   = est_timer;
    res.srtt    = est_srtt;
    res.rttvar  = est_rttvar;
    res.retries = est_retries;
    res.give_up = est_give_up;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Works in bursts; between bursts it may idle for a random
  // gap, or none. A request once presented is held until it is taken.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin : drive_blk
    rto_req_t nxt;
    if (rst_n && !(in_valid && !req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        nxt = req_backlog.pop_front();
        in_opcode          <= nxt.op;
        in_send_time_ns    <= nxt.send_ns;
        in_receive_time_ns <= nxt.recv_ns;
        in_valid           <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. Its stall style changes on its own schedule, so stalls
  // line up with every phase of the sender's bursts.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode  = RX_OPEN;
  int       rx_left  = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_ready <= ($urandom_range(0, 4) == 0);
      default:  out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor. Results are checked before the request of the same edge is
  // predicted; the latency keeps the two from ever referring to each other.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_blk
    rto_result_t want;
    rto_req_t    req;
    req_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_give_up) n_give_up++;
      if (out_retry_count == rtoeb_pkg::RETRY_MAX) n_retry_sat++;
      if (pending_results.size() == 0) begin
        flag_error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("rto_ns",      64'(want.rto),     64'(out_rto_ns));
        check_field("timer_ns",    64'(want.timer),   64'(out_timer_ns));
        check_field("srtt_ns",     64'(want.srtt),    64'(out_srtt_ns));
        check_field("rttvar_ns",   64'(want.rttvar),  64'(out_rttvar_ns));
        check_field("retry_count", 64'(want.retries), 64'(out_retry_count));
        check_field("give_up",     64'(want.give_up), 64'(out_give_up));
      end
    end
    if (req_taken) begin
      req.op      = in_opcode;
      req.send_ns = in_send_time_ns;
      req.recv_ns = in_receive_time_ns;
      case (in_opcode)
        rtoeb_pkg::OP_ARM:     n_arm++;
        rtoeb_pkg::OP_SAMPLE:  n_sample++;
        rtoeb_pkg::OP_TIMEOUT: n_timeout++;
        default:               n_unused++;
      endcase
      pending_results.push_back(advance_estimator(req));
    end
  end

  // --------------------------------------------------------------------------
  // Configuration access. Each write is followed by a read of the same
  // register; bits above the register's width are filled with junk on the
  // write, and only the register's own bits are compared on the read.
  // --------------------------------------------------------------------------
  function automatic logic [63:0] reg_mask(rtoeb_pkg::cfg_idx_t idx);
    case (idx)
      rtoeb_pkg::REG_AUTO_RTO:       return 64'h1;
      rtoeb_pkg::REG_MAX_RETRANSMIT: return 64'hFF;
      default:                       return DUR_MAX;
    endcase
  endfunction

  task automatic cfg_write(rtoeb_pkg::cfg_idx_t idx, logic [63:0] value);
    logic [63:0] mask;
    logic [63:0] kept;
    mask = reg_mask(idx);
    kept = value & mask;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= rtoeb_pkg::CFG_ADDR_BITS'(idx) << rtoeb_pkg::CFG_IDX_LSB;
    cfg_pwdata  <= kept | ({$urandom, $urandom} & ~mask);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      rtoeb_pkg::REG_AUTO_RTO:       set_auto = kept[0];
      rtoeb_pkg::REG_USER_RTO_NS:    set_user = dur_t'(kept);
      rtoeb_pkg::REG_RTO_MIN_NS:     set_min  = dur_t'(kept);
      rtoeb_pkg::REG_RTO_MAX_NS:     set_max  = dur_t'(kept);
      rtoeb_pkg::REG_MAX_RETRANSMIT: set_retx = retry_t'(kept);
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if ((cfg_prdata & mask) !== kept) begin
      flag_error($sformatf("register %0d read back 0x%0h, wrote 0x%0h",
                           idx, cfg_prdata & mask, kept));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_settings(logic auto_on, logic [63:0] user, logic [63:0] lo,
                                logic [63:0] hi, logic [63:0] retx);
    n_settings++;
    cfg_write(rtoeb_pkg::REG_AUTO_RTO,       64'(auto_on));
    cfg_write(rtoeb_pkg::REG_USER_RTO_NS,    user);
    cfg_write(rtoeb_pkg::REG_RTO_MIN_NS,     lo);
    cfg_write(rtoeb_pkg::REG_RTO_MAX_NS,     hi);
    cfg_write(rtoeb_pkg::REG_MAX_RETRANSMIT, retx);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_dur();
    return {24'd0, 8'($urandom_range(0, 255)), $urandom};
  endfunction

  function automatic ts_t rand_ts();
    return {16'($urandom_range(0, 65535)), $urandom};
  endfunction

  // Acknowledgement time for a given send time: mostly plausible round
  // trips, plus zero, negative, enormous and unrelated ones.
  function automatic ts_t recv_after(ts_t send);
    case ($urandom_range(0, 9))
      0:       return send;
      1:       return send - ts_t'($urandom_range(1, 100000));
      2, 3:    return send + ts_t'($urandom_range(1000, 10000000));
      4, 5, 6: return send + ts_t'($urandom_range(10000000, 2000000000));
      7:       return send + ts_t'(rand_dur());
      8:       return send + rand_ts();
      default: return rand_ts();
    endcase
  endfunction

  task automatic push_req(rtoeb_pkg::opcode_t op, ts_t send, ts_t recv);
    rto_req_t r;
    r.op      = op;
    r.send_ns = send;
    r.recv_ns = recv;
    req_backlog.push_back(r);
    reqs_queued++;
  endtask

  task automatic push_sample();
    ts_t s;
    case ($urandom_range(0, 15))
      0:       s = '0;
      1:       s = TS_MAX;
      default: s = rand_ts();
    endcase
    push_req(rtoeb_pkg::OP_SAMPLE, s, recv_after(s));
  endtask

  // Every request produces a result, so idle means all results are back.
  task automatic wait_drained();
    while (results_seen != reqs_queued) @(negedge clk);
  endtask

  // A connection's life: arm, then samples and runs of timeouts, with the
  // odd stray request thrown in. A phase stops at its request count.
  task automatic gen_traffic(int count);
    int goal;
    int events;
    int run;
    goal = reqs_queued + count;
    while (reqs_queued < goal) begin
      if ($urandom_range(0, 9) < 8) begin
        push_req(rtoeb_pkg::OP_ARM, rand_ts(), rand_ts());
        events = $urandom_range(1, 10);
        repeat (events) begin
          if (reqs_queued >= goal) break;
          if ($urandom_range(0, 9) < 6) begin
            push_sample();
          end else begin
            run = $urandom_range(1, 14);
            repeat (run) begin
              if (reqs_queued < goal) push_req(rtoeb_pkg::OP_TIMEOUT, rand_ts(), rand_ts());
            end
          end
        end
      end else begin
        push_req(rtoeb_pkg::opcode_t'($urandom_range(0, 3)), rand_ts(), rand_ts());
      end
      // Now and then the sender holds off until the block has gone quiet.
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] user;
    logic [63:0] retx;

    // Reset contents of the registers and the estimator.
    set_auto    = 1'b1;
    set_user    = dur_t'(rtoeb_pkg::USER_RTO_RST);
    set_min     = dur_t'(rtoeb_pkg::RTO_MIN_RST);
    set_max     = dur_t'(rtoeb_pkg::RTO_MAX_RST);
    set_retx    = rtoeb_pkg::MAX_RETRANSMIT_RST;
    est_srtt    = '0;
    est_rttvar  = '0;
    est_rto     = dur_t'(sat_dur(rtoeb_pkg::INITIAL_RTO_NS));
    est_timer   = est_rto;
    est_retries = '0;
    est_give_up = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration: the reset state itself,
    // zero, negative and saturating round trips, timestamp extremes, a run of
    // timeouts past the default retry limit and the unused opcode.
    push_req(rtoeb_pkg::OP_NONE, TS_MAX, TS_MAX);
    push_req(rtoeb_pkg::OP_ARM, '0, '0);
    push_req(rtoeb_pkg::OP_SAMPLE, '0, '0);
    push_req(rtoeb_pkg::OP_SAMPLE, TS_MAX, '0);
    push_req(rtoeb_pkg::OP_SAMPLE, '0, TS_MAX);
    push_req(rtoeb_pkg::OP_SAMPLE, TS_MAX, TS_MAX);
    push_req(rtoeb_pkg::OP_SAMPLE, ts_t'(1000000), ts_t'(101000000));
    repeat (11) push_req(rtoeb_pkg::OP_TIMEOUT, '0, '0);
    push_req(rtoeb_pkg::OP_NONE, '0, '0);
    push_req(rtoeb_pkg::OP_ARM, TS_MAX, TS_MAX);
    push_req(rtoeb_pkg::OP_SAMPLE, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA + 48'd50000000);
    push_req(rtoeb_pkg::OP_TIMEOUT, 48'h5555_5555_5555, 48'h5555_5555_5555);
    push_req(rtoeb_pkg::OP_ARM, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    wait_drained();

    // Widest window, no retries allowed: large samples push SRTT + 4*RTTVAR
    // and the doubled timer into saturation.
    apply_settings(1'b1, 64'd0, 64'd0, DUR_MAX, 64'd0);
    gen_traffic(80);
    wait_drained();

    // Manual mode with a zero user value and the largest retry limit.
    apply_settings(1'b0, 64'd0, 64'd0, DUR_MAX, 64'd255);
    gen_traffic(80);
    wait_drained();

    // Manual mode, largest user value, and a minimum above the maximum.
    apply_settings(1'b0, DUR_MAX, 64'd500000000, 64'd100000000, 64'd3);
    gen_traffic(80);
    wait_drained();

    // Window collapsed to one value, and then collapsed at the very top.
    apply_settings(1'b1, rand_dur(), 64'd1000000000, 64'd1000000000, 64'd5);
    gen_traffic(40);
    wait_drained();
    apply_settings(1'b1, rand_dur(), DUR_MAX, DUR_MAX, 64'd1);
    gen_traffic(40);
    wait_drained();

    // A long run of timeouts drives the retry counter into saturation; with
    // a limit one below its ceiling the give-up flag rises on the last step.
    apply_settings(1'b1, 64'd1000000000, 64'd1000, DUR_MAX, 64'd254);
    push_req(rtoeb_pkg::OP_ARM, '0, '0);
    repeat (3) push_sample();
    repeat (260) push_req(rtoeb_pkg::OP_TIMEOUT, rand_ts(), rand_ts());
    push_sample();
    push_req(rtoeb_pkg::OP_ARM, '0, '0);
    wait_drained();

    // Random settings, now and then at an extreme.
    repeat (6) begin
      case ($urandom_range(0, 3))
        0:       lo = 64'd0;
        1:       lo = 64'($urandom_range(0, 500000000));
        2:       lo = rand_dur();
        default: lo = 64'($urandom_range(1000, 300000000));
      endcase
      case ($urandom_range(0, 3))
        0:       hi = DUR_MAX;
        1:       hi = rand_dur();
        default: hi = 64'($urandom_range(1, 64)) * 64'd1000000000;
      endcase
      user = ($urandom_range(0, 1) == 0) ? rand_dur() : 64'($urandom);
      retx = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 255)) :
                                           64'($urandom_range(0, 12));
      apply_settings(1'($urandom_range(0, 1)), user, lo, hi, retx);
      gen_traffic(85);
      wait_drained();
    end

    // Let anything still in the pipeline show up before judging.
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d predicted results never arrived", pending_results.size()));
    end

    $display("Summary: %0d requests (%0d arm, %0d sample, %0d timeout, %0d unused op)",
             n_arm + n_sample + n_timeout + n_unused, n_arm, n_sample, n_timeout, n_unused);
    $display("Summary: %0d register settings, give-up on %0d results, retries at ceiling on %0d",
             n_settings, n_give_up, n_retry_sat);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Safety net in case the block hangs a handshake.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
